[src/bsd_pkg.sv]
package bsd_pkg;

    localparam int unsigned MAX_FRAME_LENGTH_DEF = 4096;

    localparam logic [7:0] HEADER_BYTE_RST = 8'd126;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;
    localparam logic [3:0] HEADER_RUN_RST  = 4'd2;
    localparam logic [3:0] FLAG_RUN_MAX    = 4'd15;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_HEADER = 2'd1,
        MODE_DATA   = 2'd2,
        MODE_ESCAPE = 2'd3
    } t_rx_mode;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_HEADER_BYTE = 2'd0,
        CFG_ESCAPE_BYTE = 2'd1,
        CFG_HEADER_RUN  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [11:0] byte_index;
        logic [12:0] frame_length;
        logic        overflow;
        t_rx_mode    rx_state;
    } t_result;

endpackage

[src/byte_stuffing_deframer.sv]
// Byte-stuffing deframer: one raw link byte per input word, one result word per byte. A byte is
// taken in every cycle unless o_in_stall is high. The output side holds two words: each result
// goes to the output register, or to a skid register if that is held, so i_out_stall only reaches
// o_in_stall once both are full. Frames open after header_run flag bytes and a non-flag byte, and
// close after header_run flags in a row; the escape byte makes the next byte literal. Payload past
// MAX_FRAME_LENGTH bytes is dropped and flagged as overflow. Users must write configuration
// registers through the cfg port (always ready) only while no bytes are in flight; not enforced.
module byte_stuffing_deframer
    import bsd_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [11:0] o_byte_index,
    output logic [12:0] o_frame_length,
    output logic        o_overflow,
    output logic [1:0]  o_rx_state,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAME_LENGTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_LENGTH);

    logic [7:0]       r_header_byte;
    logic [7:0]       r_escape_byte;
    logic [3:0]       r_header_run;

    t_rx_mode         r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [3:0]       r_flag, n_flag;
    logic             r_ovf, n_ovf;

    t_result          r_out, r_skid, n_res;
    logic             r_out_valid, r_skid_valid;

    logic             w_in_acc, w_out_take;
    logic             w_is_flag, w_is_esc;
    logic [3:0]       w_flag_bump;
    logic             w_take, w_keep, w_close;
    logic [CNT_W-1:0] w_base;
    logic [31:0]      w_base_ext, w_count_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;

    assign w_is_flag   = (i_rx_byte == r_header_byte);
    assign w_is_esc    = (i_rx_byte == r_escape_byte);
    assign w_flag_bump = (r_flag == FLAG_RUN_MAX) ? r_flag : r_flag + 4'd1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= HEADER_BYTE_RST;
            r_escape_byte <= ESCAPE_BYTE_RST;
            r_header_run  <= HEADER_RUN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_HEADER_BYTE: r_header_byte <= i_cfg_data;
                CFG_ESCAPE_BYTE: r_escape_byte <= i_cfg_data;
                CFG_HEADER_RUN:  r_header_run  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_flag  = r_flag;
        n_count = r_count;
        n_ovf   = r_ovf;
        w_take  = 1'b0;
        w_close = 1'b0;
        case (r_mode)
            MODE_IDLE: begin
                if (w_is_flag) begin
                    n_flag = w_flag_bump;
                    n_mode = MODE_HEADER;
                end
            end
            MODE_HEADER: begin
                if (w_is_flag) begin
                    n_flag = w_flag_bump;
                end else if (r_flag >= r_header_run) begin
                    n_flag  = 4'd0;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    if (w_is_esc) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        w_take = 1'b1;
                        n_mode = MODE_DATA;
                    end
                end else begin
                    n_flag = 4'd0;
                end
            end
            MODE_DATA: begin
                if (w_is_flag) begin
                    n_flag = w_flag_bump;
                    if (w_flag_bump >= r_header_run) begin
                        w_close = 1'b1;
                        n_flag  = 4'd0;
                        n_ovf   = 1'b0;
                        n_mode  = MODE_IDLE;
                    end
                end else begin
                    n_flag = 4'd0;
                    if (w_is_esc) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        w_take = 1'b1;
                    end
                end
            end
            MODE_ESCAPE: begin
                w_take = 1'b1;
                n_mode = MODE_DATA;
            end
            default: ;
        endcase
        // payload store with frame-full check
        w_base = n_count;
        w_keep = w_take && (w_base < CNT_MAX);
        if (w_keep) begin
            n_count = w_base + CNT_W'(1);
        end else if (w_take) begin
            n_ovf = 1'b1;
        end
    end

    assign w_base_ext  = 32'(w_base);
    assign w_count_ext = 32'(r_count);

    // result word
    always_comb begin
        n_res          = '0;
        n_res.rx_state = n_mode;
        if (w_close) begin
            n_res.kind         = KIND_END;
            n_res.frame_length = w_count_ext[12:0];
            n_res.overflow     = r_ovf;
        end else begin
            if (w_keep) begin
                n_res.kind       = KIND_PAYLOAD;
                n_res.data_byte  = i_rx_byte;
                n_res.byte_index = w_base_ext[11:0];
            end else begin
                n_res.kind = KIND_NONE;
            end
            n_res.overflow = (n_mode == MODE_DATA || n_mode == MODE_ESCAPE) ? n_ovf : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_flag  <= 4'd0;
            r_ovf   <= 1'b0;
        end else if (w_in_acc) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_flag  <= n_flag;
            r_ovf   <= n_ovf;
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take) begin
                r_out <= r_skid;
            end
        end else if (w_in_acc) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_length = r_out.frame_length;
    assign o_overflow     = r_out.overflow;
    assign o_rx_state     = r_out.rx_state;

endmodule

[src/bsd_checker.sv]
module bsd_checker
    import bsd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_data_byte,
    input logic [12:0] o_frame_length,
    input logic        o_overflow,
    input logic [1:0]  o_rx_state
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
            && $stable(o_data_byte) && $stable(o_frame_length))
        else $error("result word changed while stalled");

    // frame end always leaves the deframer idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_END |-> o_rx_state == MODE_IDLE)
        else $error("frame end without return to idle");

    // payload only comes out in data state
    a_payload_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_PAYLOAD |-> o_rx_state == MODE_DATA)
        else $error("payload byte outside data state");

    // overflow only inside a frame or on its close
    a_ovf_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_kind == KIND_END || o_rx_state == MODE_DATA
            || o_rx_state == MODE_ESCAPE)
        else $error("overflow reported outside a frame");

endmodule

bind byte_stuffing_deframer bsd_checker u_bsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_data_byte    (o_data_byte),
    .o_frame_length (o_frame_length),
    .o_overflow     (o_overflow),
    .o_rx_state     (o_rx_state)
);
